@@ hdl/lcdseq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types and constants for the character LCD sequencer
// Transaction structs, the init byte and pause tables, and sizes derived
// from the value width.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

	localparam int VALUE_WIDTH = 32;
	// decimal digits of 2**(VALUE_WIDTH-1), rounded up
	localparam int NDIG        = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int DIG_IW      = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int BCD_W       = 4 * NDIG;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int INIT_LEN    = 28;
	localparam int IDX_W       = $clog2(INIT_LEN);

	localparam logic [3:0] CHAR_HI_DIGIT = 4'h3;
	localparam logic [3:0] SUFFIX_HI     = 4'h5;
	localparam logic [3:0] SUFFIX_LO     = 4'h6;
	localparam logic [3:0] CTL_EN_HIGH   = 4'hD;  // BL EN - RS
	localparam logic [3:0] CTL_EN_LOW    = 4'h9;  // BL -- - RS

	localparam logic OP_INIT   = 1'b0;
	localparam logic OP_NUMBER = 1'b1;

	typedef struct packed {
		logic                          operation;
		logic signed [VALUE_WIDTH-1:0] shown_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  expander_byte;
		logic [13:0] pause_before_us;
		logic        last_byte;
	} wr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bcd_stat_t;

	function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] i);
		logic [7:0] b;
		case (i)
			5'd0, 5'd2, 5'd4:                      b = 8'h34;
			5'd1, 5'd3, 5'd5:                      b = 8'h30;
			5'd6, 5'd8:                            b = 8'h24;
			5'd7, 5'd9:                            b = 8'h20;
			5'd10, 5'd14:                          b = 8'h84;
			5'd11, 5'd15:                          b = 8'h80;
			5'd12, 5'd16, 5'd20, 5'd24:            b = 8'h04;
			5'd13, 5'd17, 5'd21, 5'd25:            b = 8'h00;
			5'd18:                                 b = 8'h14;
			5'd19:                                 b = 8'h10;
			5'd22:                                 b = 8'h64;
			5'd23:                                 b = 8'h60;
			5'd26:                                 b = 8'hE4;
			5'd27:                                 b = 8'hE0;
			default:                               b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [13:0] init_pause(input logic [IDX_W-1:0] i);
		logic [13:0] p;
		case (i)
			5'd0:                                  p = 14'd15000;
			5'd2, 5'd6:                            p = 14'd4100;
			5'd4:                                  p = 14'd100;
			5'd8, 5'd12, 5'd16, 5'd20, 5'd24:      p = 14'd40;
			default:                               p = 14'd0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

@@ hdl/lcdseq_bcd.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_bcd: iterative binary to BCD converter
// Takes the magnitude of a signed value and runs one shift-and-add-3 step
// per cycle, VALUE_WIDTH steps in all.
// ----------------------------------------------------------------------------
module lcdseq_bcd import lcdseq_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output      bcd_stat_t                     stat,
	output      logic [BCD_W-1:0]              digits
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [VALUE_WIDTH-1:0] v_raw;
	logic [VALUE_WIDTH-1:0] v_abs;
	logic [BCD_W-1:0]       adj;

	assign v_raw = value;
	assign v_abs = v_raw[VALUE_WIDTH-1] ? (~v_raw + 1'b1) : v_raw;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                           : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= v_abs;
			bcd_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign digits    = bcd_q;

	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("bcd busy and done together");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("bcd done without a run");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0) else $error("bcd count left over when idle");

endmodule
`default_nettype wire

@@ hdl/char_lcd_number_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_number_sequencer: byte stream for a 4-bit character LCD behind
// an I2C port expander
// Turns init and number commands into expander bytes with their pauses.
// ----------------------------------------------------------------------------
// An init command produces the 28-byte reset and mode sequence at one byte
// per cycle while the output is not stalled. A number command first runs
// the shift-and-add-3 BCD unit through its 32 shift steps and waits for
// its done flag, then skips each leading zero digit (up to 9), then emits
// four bytes per digit and four for the suffix 'V', one byte per cycle
// while the output is not stalled. The command channel stalls for the
// whole run of a command; the last byte carries last_byte.
module char_lcd_number_sequencer import lcdseq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output      logic cmd_stall,
	input  wire cmd_t cmd,
	output      logic wr_valid,
	input  wire logic wr_stall,
	output      wr_t  wr
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INIT = 2'd1;
	localparam logic [1:0] ST_CONV = 2'd2;
	localparam logic [1:0] ST_NUM  = 2'd3;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [DIG_IW-1:0] dig_q;
	logic [1:0]        ph_q;
	logic              suffix_q;
	logic              started_q;
	logic              wr_valid_q;
	wr_t               wr_q;

	logic              cmd_acc;
	logic              out_ready;
	logic              emit;
	logic              bcd_start;
	bcd_stat_t         bcd_stat;
	logic [BCD_W-1:0]  digits;
	logic [3:0]        cur_dig;
	logic              skip;
	logic [3:0]        nib;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign bcd_start = cmd_acc && (cmd.operation == OP_NUMBER);
	assign out_ready = !wr_valid_q || !wr_stall;
	assign emit      = out_ready && ((state_q == ST_INIT) || (state_q == ST_NUM && !skip));

	lcdseq_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (cmd.shown_value),
		.stat   (bcd_stat),
		.digits (digits)
	);

	assign cur_dig = digits[{dig_q, 2'b00} +: 4];
	assign skip    = !suffix_q && !started_q && (ph_q == 2'd0) &&
	                 (cur_dig == 4'd0) && (dig_q != '0);

	always_comb begin
		if (suffix_q) begin
			nib = ph_q[1] ? SUFFIX_LO : SUFFIX_HI;
		end else begin
			nib = ph_q[1] ? cur_dig : CHAR_HI_DIGIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			dig_q      <= '0;
			ph_q       <= '0;
			suffix_q   <= 1'b0;
			started_q  <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			wr_valid_q <= emit || (wr_valid_q && wr_stall);
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						idx_q   <= '0;
						state_q <= (cmd.operation == OP_NUMBER) ? ST_CONV : ST_INIT;
					end
				end
				ST_INIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == IDX_W'(INIT_LEN - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CONV: begin
					if (bcd_stat.done) begin
						dig_q     <= DIG_IW'(NDIG - 1);
						ph_q      <= '0;
						suffix_q  <= 1'b0;
						started_q <= 1'b0;
						state_q   <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (skip) begin
						dig_q <= dig_q - 1'b1;
					end else if (out_ready) begin
						started_q <= 1'b1;
						ph_q      <= ph_q + 1'b1;
						if (ph_q == 2'd3) begin
							if (suffix_q) begin
								suffix_q <= 1'b0;
								state_q  <= ST_IDLE;
							end else if (dig_q == '0) begin
								suffix_q <= 1'b1;
							end else begin
								dig_q <= dig_q - 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT && out_ready) begin
			wr_q.expander_byte   <= init_byte(idx_q);
			wr_q.pause_before_us <= init_pause(idx_q);
			wr_q.last_byte       <= (idx_q == IDX_W'(INIT_LEN - 1));
		end else if (state_q == ST_NUM && !skip && out_ready) begin
			wr_q.expander_byte   <= {nib, ph_q[0] ? CTL_EN_LOW : CTL_EN_HIGH};
			wr_q.pause_before_us <= '0;
			wr_q.last_byte       <= suffix_q && (ph_q == 2'd3);
		end
	end

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

	a_init_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |-> idx_q <= IDX_W'(INIT_LEN - 1))
		else $error("init index out of range");
	a_num_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NUM |-> !bcd_stat.busy)
		else $error("emitting digits while conversion runs");
	a_suffix_in_num: assert property (@(posedge clk) disable iff (!arst_n)
		suffix_q |-> state_q == ST_NUM)
		else $error("suffix flag outside number emission");
	a_conv_running: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_CONV) |-> bcd_stat.busy)
		else $error("conversion not started");

endmodule
`default_nettype wire
